// ----- rtl/yuvc_pkg.sv -----
// Shared constants, fixed-point coefficients and the pixel item type for the
// NV12 to RGB888 converter. No dependencies.
`default_nettype none

package yuvc_pkg;

  localparam int MAX_WIDTH      = 4096;
  localparam int COEF_FRAC_BITS = 14;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W     = COL_W - 1;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;

  localparam int LW_W     = 13;
  localparam int LW_RESET = 640;
  localparam int PIX_W    = 8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // coefficient = round(c * 2^F), c given in units of 1e-5
  localparam longint K_R_CR = (longint'(113983) * (longint'(1) << COEF_FRAC_BITS) + 50000) / 100000;
  localparam longint K_G_CB = (longint'(39465) * (longint'(1) << COEF_FRAC_BITS) + 50000) / 100000;
  localparam longint K_G_CR = (longint'(58060) * (longint'(1) << COEF_FRAC_BITS) + 50000) / 100000;
  localparam longint K_B_CB = (longint'(203211) * (longint'(1) << COEF_FRAC_BITS) + 50000) / 100000;

  // signed accumulator: Y scaled plus up to two products of ~F+2 bit coef by 9-bit chroma
  localparam int ACC_W = COEF_FRAC_BITS + 13;

  typedef struct packed {
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] cb;
    logic [PIX_W-1:0] cr;
    logic             row_end;
  } yuvc_item_t;

endpackage

`default_nettype wire

// ----- rtl/yuvc_front.sv -----
// Front end: width register, column/row tracking, chroma line store and
// pair selection. Depends on yuvc_pkg.
`default_nettype none

module yuvc_front import yuvc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [LW_W-1:0]  cfg_line_width_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [PIX_W-1:0] luma_value_i,
  input  wire logic [PIX_W-1:0] chroma_blue_i,
  input  wire logic [PIX_W-1:0] chroma_red_i,
  input  wire logic             frame_start_i,
  input  wire logic             room_i,
  output logic                  item_valid_o,
  output yuvc_item_t            item_o
);

  logic [LW_W-1:0]    line_width_q;
  logic [COL_W-1:0]   col_q;
  logic               odd_q;
  logic [2*PIX_W-1:0] cur_q;

  logic               f_v_q;
  logic [PIX_W-1:0]   f_luma_q;
  logic [2*PIX_W-1:0] f_pair_q;
  logic               f_odd_q;
  logic               f_end_q;

  logic [2*PIX_W-1:0] line_mem [LINE_DEPTH];
  logic [2*PIX_W-1:0] rd_q;

  logic [COL_W-1:0]   wm1;
  logic [COL_W-1:0]   col;
  logic               odd;
  logic               last;
  logic               lead;
  logic               acc;
  logic [SLOT_W-1:0]  slot;
  logic [2*PIX_W-1:0] in_pair;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = room_i;
  assign acc         = in_valid_i && room_i;
  assign in_pair     = {chroma_red_i, chroma_blue_i};

  always_comb begin
    if (line_width_q < LW_W'(2)) begin
      wm1 = COL_W'(1);
    end else if (32'(line_width_q) > MAX_WIDTH) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(line_width_q - LW_W'(1));
    end
    col  = frame_start_i ? '0 : col_q;
    odd  = frame_start_i ? 1'b0 : odd_q;
    last = (col >= wm1);
    lead = !odd && !col[0];
    slot = col[COL_W-1:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LW_W'(LW_RESET);
      col_q        <= '0;
      odd_q        <= 1'b0;
      cur_q        <= '0;
      f_v_q        <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        line_width_q <= cfg_line_width_i;
      end
      f_v_q <= acc;
      if (acc) begin
        col_q <= last ? '0 : col + COL_W'(1);
        odd_q <= last ? !odd : odd;
        if (lead) begin
          cur_q <= in_pair;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      f_luma_q <= luma_value_i;
      f_pair_q <= lead ? in_pair : cur_q;
      f_odd_q  <= odd;
      f_end_q  <= last;
    end
  end

  // chroma line store: even rows write, odd rows read
  always_ff @(posedge clk_i) begin
    if (acc && lead) begin
      line_mem[slot] <= in_pair;
    end
    if (acc && odd) begin
      rd_q <= line_mem[slot];
    end
  end

  always_comb begin
    item_valid_o     = f_v_q;
    item_o.luma      = f_luma_q;
    item_o.cb        = f_odd_q ? rd_q[PIX_W-1:0] : f_pair_q[PIX_W-1:0];
    item_o.cr        = f_odd_q ? rd_q[2*PIX_W-1:PIX_W] : f_pair_q[2*PIX_W-1:PIX_W];
    item_o.row_end   = f_end_q;
  end

endmodule

`default_nettype wire

// ----- rtl/yuvc_queue.sv -----
// Short FIFO between front and back; reports room for one more beat counting
// the beat still in the front stage. Depends on yuvc_pkg.
`default_nettype none

module yuvc_queue import yuvc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire yuvc_item_t  item_i,
  output logic             room_o,
  input  wire logic        pop_i,
  output logic             valid_o,
  output yuvc_item_t       item_o
);

  yuvc_item_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic [QCNT_W-1:0] count_d;

  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign room_o  = (count_q + QCNT_W'(push_i)) < QCNT_W'(QUEUE_DEPTH);

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/yuvc_back.sv -----
// Back end: two-stage color matrix (products, then sums with clamp) feeding
// the output register. Depends on yuvc_pkg.
`default_nettype none

module yuvc_back import yuvc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire yuvc_item_t  item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [PIX_W-1:0] red_o,
  output logic [PIX_W-1:0] green_o,
  output logic [PIX_W-1:0] blue_o,
  output logic             row_end_o
);

  localparam logic signed [ACC_W-1:0] KR  = ACC_W'(K_R_CR);
  localparam logic signed [ACC_W-1:0] KGB = ACC_W'(K_G_CB);
  localparam logic signed [ACC_W-1:0] KGR = ACC_W'(K_G_CR);
  localparam logic signed [ACC_W-1:0] KB  = ACC_W'(K_B_CB);

  function automatic logic [PIX_W-1:0] clip(input logic signed [ACC_W-1:0] s);
    logic [PIX_W-1:0] r;
    if (s[ACC_W-1]) begin
      r = '0;
    end else if (|s[ACC_W-2:COEF_FRAC_BITS+PIX_W]) begin
      r = '1;
    end else begin
      r = s[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
    end
    return r;
  endfunction

  logic                    s1_v_q;
  logic signed [ACC_W-1:0] ys_q, pr_q, pgb_q, pgr_q, pb_q;
  logic                    s1_end_q;
  logic                    s2_v_q;
  logic                    s1_adv;

  logic signed [ACC_W-1:0] cb_s, cr_s, ys_d, pr_d, pgb_d, pgr_d, pb_d;
  logic signed [ACC_W-1:0] sr, sg, sb;

  assign s1_adv      = s1_v_q && (!s2_v_q || out_ready_i);
  assign pop_o       = valid_i && (!s1_v_q || s1_adv);
  assign out_valid_o = s2_v_q;

  always_comb begin
    cb_s  = ACC_W'(signed'({1'b0, item_i.cb}) - 128);
    cr_s  = ACC_W'(signed'({1'b0, item_i.cr}) - 128);
    ys_d  = ACC_W'({item_i.luma, COEF_FRAC_BITS'(0)});
    pr_d  = KR * cr_s;
    pgb_d = KGB * cb_s;
    pgr_d = KGR * cr_s;
    pb_d  = KB * cb_s;
    sr    = ys_q + pr_q;
    sg    = ys_q - pgb_q - pgr_q;
    sb    = ys_q + pb_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= 1'b1;
      end else if (out_ready_i) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ys_q     <= ys_d;
      pr_q     <= pr_d;
      pgb_q    <= pgb_d;
      pgr_q    <= pgr_d;
      pb_q     <= pb_d;
      s1_end_q <= item_i.row_end;
    end
    if (s1_adv) begin
      red_o     <= clip(sr);
      green_o   <= clip(sg);
      blue_o    <= clip(sb);
      row_end_o <= s1_end_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/yuv420_semiplanar_to_rgb.sv -----
// Streaming NV12 (4:2:0, interleaved Cb/Cr) to RGB888 converter, top level.
// Depends on yuvc_pkg, yuvc_front, yuvc_queue and yuvc_back.
//
// One luma beat in and one RGB beat out per clock, sustained while out_ready
// is held high. The accept edge itself loads the front stage and its
// registered chroma line-store read, the next edge writes the four-entry
// queue, and the back end then registers first the coefficient multiplies,
// then the sums with clamp into the output register. The queue absorbs output
// stalls so the input keeps flowing until it fills. The line store holds
// MAX_WIDTH/2 Cb/Cr pairs; odd rows read what the even row above wrote.
// line_width may be written only while the block is idle.
`default_nettype none

module yuv420_semiplanar_to_rgb import yuvc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [LW_W-1:0]  cfg_line_width_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [PIX_W-1:0] luma_value_i,
  input  wire logic [PIX_W-1:0] chroma_blue_i,
  input  wire logic [PIX_W-1:0] chroma_red_i,
  input  wire logic             frame_start_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [PIX_W-1:0]      red_o,
  output logic [PIX_W-1:0]      green_o,
  output logic [PIX_W-1:0]      blue_o,
  output logic                  row_end_o
);

  logic       room;
  logic       f_valid;
  yuvc_item_t f_item;
  logic       q_valid;
  yuvc_item_t q_item;
  logic       pop;

  yuvc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_line_width_i (cfg_line_width_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .luma_value_i     (luma_value_i),
    .chroma_blue_i    (chroma_blue_i),
    .chroma_red_i     (chroma_red_i),
    .frame_start_i    (frame_start_i),
    .room_i           (room),
    .item_valid_o     (f_valid),
    .item_o           (f_item)
  );

  yuvc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .item_i  (f_item),
    .room_o  (room),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  yuvc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .row_end_o   (row_end_o)
  );

endmodule

`default_nettype wire

// ----- rtl/yuvc_checker.sv -----
// Port-level checker for the converter top level, attached by bind.
// Depends on the top level's ports only.
`default_nettype none

module yuvc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [7:0]  red_o,
  input wire logic [7:0]  green_o,
  input wire logic [7:0]  blue_o,
  input wire logic        row_end_o
);

  logic       in_beat;
  logic       out_beat;
  logic [3:0] pend_q;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(in_beat) - 4'(out_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable({red_o, green_o, blue_o, row_end_o}))
    else $error("output payload changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> pend_q != 4'd0)
    else $error("output beat without a pending input beat");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'd7)
    else $error("more beats in flight than the pipeline holds");

endmodule

bind yuv420_semiplanar_to_rgb yuvc_checker u_yuvc_checker (.*);

`default_nettype wire
